FILE: src/tns_pkg.sv
`timescale 1ns / 1ps
// types, codes and constants shared by the tone note sequencer modules
// no dependencies
package tns_pkg;

  localparam int NOTE_DEPTH = 256;
  localparam int NOTE_LIMIT = (NOTE_DEPTH < 256) ? NOTE_DEPTH : 256;
  localparam int NOTE_AW    = (NOTE_LIMIT > 1) ? $clog2(NOTE_LIMIT) : 1;

  localparam int IDX_W   = 8;
  localparam int OWNER_W = 8;
  localparam int PITCH_W = 16;
  localparam int DUR_W   = 16;
  localparam int CLK_W   = 24;
  localparam int ELAP_W  = 32;
  localparam int NOTE_W  = PITCH_W + DUR_W;

  localparam logic [IDX_W:0] NOTE_LIMIT_V = (IDX_W + 1)'(NOTE_LIMIT);

  localparam logic [DUR_W-1:0]   TONE_TICKS    = 16'hffff;
  localparam logic [PITCH_W-1:0] DIVISOR_MAX   = 16'hffff;
  localparam logic [CLK_W-1:0]   TONE_CLK_RST  = 24'd1193182;
  localparam logic [PITCH_W-1:0] QUIET_PITCH_RST = 16'd59659;

  // divider steps, one quotient bit per cycle
  localparam int DIV_STEPS = CLK_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // command queue between front and back
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_FIFO_AW    = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;

  // configuration register indexes
  localparam logic REG_TONE_CLK    = 1'b0;
  localparam logic REG_QUIET_PITCH = 1'b1;
  localparam int   CFG_AW          = 3;

  // func codes of an input word
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_LOAD   = 3'd1;
  localparam logic [2:0] FUNC_SONG   = 3'd2;
  localparam logic [2:0] FUNC_TONE   = 3'd3;
  localparam logic [2:0] FUNC_PAUSE  = 3'd4;
  localparam logic [2:0] FUNC_RESUME = 3'd5;
  localparam logic [2:0] FUNC_STOP   = 3'd6;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SONG   = 3'd2,
    OP_TONE   = 3'd3,
    OP_PAUSE  = 3'd4,
    OP_RESUME = 3'd5,
    OP_STOP   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [OWNER_W-1:0] owner_id;
    logic [IDX_W-1:0]   note_index;
    logic [PITCH_W-1:0] pitch_hz;
    logic [DUR_W-1:0]   duration_ticks;
  } in_t;

  typedef struct packed {
    logic               speaker_enabled;
    logic [PITCH_W-1:0] tone_divisor;
    logic [1:0]         play_state;
    logic [IDX_W-1:0]   current_note;
    logic [DUR_W-1:0]   ticks_remaining;
    logic [ELAP_W-1:0]  elapsed_ticks;
    logic [OWNER_W-1:0] current_owner;
    logic               refused;
  } out_t;

  // classified command between front and back
  typedef struct packed {
    op_t                op;
    logic [OWNER_W-1:0] owner;
    logic [IDX_W-1:0]   idx;
    logic               idx_ok;
    logic [PITCH_W-1:0] pitch;
    logic [DUR_W-1:0]   dur;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [CLK_W-1:0]   dividend;
    logic [PITCH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [PITCH_W-1:0] quotient;
  } div_rsp_t;

  // a zero pitch falls back to the rest pitch
  function automatic logic [PITCH_W-1:0] sound_pitch(input logic [PITCH_W-1:0] raw,
                                                     input logic [PITCH_W-1:0] rest);
    return (raw != '0) ? raw : rest;
  endfunction

endpackage

FILE: src/tns_cmd_fifo.sv
`timescale 1ns / 1ps
// two-entry command queue between the front and back of the sequencer
// depends on tns_pkg
module tns_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tns_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output tns_pkg::cmd_t pop_cmd,
  output logic          not_empty
);
  import tns_pkg::*;

  cmd_t                     entry_r [CMD_FIFO_DEPTH];
  logic [CMD_FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CMD_FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CMD_FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (CMD_FIFO_AW + 1)'(CMD_FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/tns_front.sv
`timescale 1ns / 1ps
// front end: takes input words and classifies them into queue commands
// depends on tns_pkg and tns_cmd_fifo
module tns_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tns_pkg::in_t  in_data,
  input  logic          pop,
  output tns_pkg::cmd_t pop_cmd,
  output logic          not_empty
);
  import tns_pkg::*;

  logic full;
  logic push;
  cmd_t cmd;

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  always_comb begin
    cmd.owner  = in_data.owner_id;
    cmd.idx    = in_data.note_index;
    cmd.idx_ok = ({1'b0, in_data.note_index} < NOTE_LIMIT_V);
    cmd.pitch  = in_data.pitch_hz;
    cmd.dur    = in_data.duration_ticks;
    case (in_data.func)
      FUNC_TICK:   cmd.op = OP_TICK;
      FUNC_LOAD:   cmd.op = OP_LOAD;
      FUNC_SONG:   cmd.op = OP_SONG;
      FUNC_TONE:   cmd.op = OP_TONE;
      FUNC_PAUSE:  cmd.op = OP_PAUSE;
      FUNC_RESUME: cmd.op = OP_RESUME;
      FUNC_STOP:   cmd.op = OP_STOP;
      default:     cmd.op = OP_NOP;
    endcase
  end

  tns_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (cmd),
    .full      (full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

endmodule

FILE: src/tns_divider.sv
`timescale 1ns / 1ps
// restoring divider for the tone divisor, one quotient bit per cycle, saturating
// depends on tns_pkg
module tns_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  tns_pkg::div_req_t req,
  output tns_pkg::div_rsp_t rsp
);
  import tns_pkg::*;

  logic [PITCH_W-1:0] rem_r, rem_nxt;
  logic [CLK_W-1:0]   quo_r, quo_nxt;
  logic [PITCH_W-1:0] dvsr_r;
  logic [DIV_CW-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [PITCH_W:0]   shifted;
  logic               fits;

  assign shifted = {rem_r, quo_r[CLK_W-1]};
  assign fits    = (shifted >= {1'b0, dvsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      cnt_nxt  = DIV_CW'(DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? PITCH_W'(shifted - {1'b0, dvsr_r}) : shifted[PITCH_W-1:0];
      quo_nxt = {quo_r[CLK_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      dvsr_r <= req.divisor;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = (quo_r[CLK_W-1:PITCH_W] != '0) ? DIVISOR_MAX : quo_r[PITCH_W-1:0];

endmodule

FILE: src/tns_back.sv
`timescale 1ns / 1ps
// back end: note store, play state and command execution, result register
// depends on tns_pkg; drives the shared tns_divider through div_req/div_rsp
module tns_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tns_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  logic [tns_pkg::CLK_W-1:0]   tone_clk,
  input  logic [tns_pkg::PITCH_W-1:0] quiet_pitch,
  output tns_pkg::div_req_t  div_req,
  input  tns_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output tns_pkg::out_t      out_data
);
  import tns_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_NOTE = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [DUR_W-1:0]   ticks_r, ticks_nxt;
  logic [ELAP_W-1:0]  elapsed_r, elapsed_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic               single_r, single_nxt;
  logic [PITCH_W-1:0] tpitch_r, tpitch_nxt;
  logic [PITCH_W-1:0] div_r, div_nxt;
  logic               en_r, en_nxt;
  logic               refused_r, refused_nxt;
  cmd_t               cmd_r, cmd_nxt;

  logic [NOTE_W-1:0]  note_mem [NOTE_LIMIT];
  logic [NOTE_W-1:0]  rd_data_r;
  logic               mem_we;
  logic               rd_en;
  logic [NOTE_AW-1:0] rd_addr;

  logic               prog_go;
  logic [PITCH_W-1:0] prog_hz;
  logic [DUR_W-1:0]   tick_dec;
  logic [IDX_W:0]     ptr_inc;
  logic               next_ok;
  logic               ptr_ok;

  assign tick_dec = ticks_r - 1'b1;
  assign ptr_inc  = {1'b0, ptr_r} + 1'b1;
  assign next_ok  = (ptr_inc < NOTE_LIMIT_V);
  assign ptr_ok   = ({1'b0, ptr_r} < NOTE_LIMIT_V);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    ptr_nxt     = ptr_r;
    ticks_nxt   = ticks_r;
    elapsed_nxt = elapsed_r;
    owner_nxt   = owner_r;
    single_nxt  = single_r;
    tpitch_nxt  = tpitch_r;
    div_nxt     = div_r;
    en_nxt      = en_r;
    refused_nxt = refused_r;
    cmd_nxt     = cmd_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = ptr_r[NOTE_AW-1:0];
    prog_go     = 1'b0;
    prog_hz     = '0;
    div_req.start    = 1'b0;
    div_req.dividend = tone_clk;
    div_req.divisor  = prog_hz;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_cmd;
          refused_nxt = 1'b0;
          state_nxt   = ST_OUT;
          case (q_cmd.op)
            OP_TICK: begin
              if (mode_r == MODE_PLAYING) begin
                elapsed_nxt = elapsed_r + 1'b1;
                ticks_nxt   = tick_dec;
                if (tick_dec == '0) begin
                  if (single_r || !next_ok) begin
                    mode_nxt = MODE_STOPPED;
                    en_nxt   = 1'b0;
                  end else begin
                    ptr_nxt   = ptr_inc[IDX_W-1:0];
                    rd_en     = 1'b1;
                    rd_addr   = ptr_inc[NOTE_AW-1:0];
                    state_nxt = ST_RD;
                  end
                end
              end
            end
            OP_LOAD: begin
              mem_we = q_cmd.idx_ok;
            end
            OP_SONG: begin
              mode_nxt    = MODE_PLAYING;
              single_nxt  = 1'b0;
              owner_nxt   = q_cmd.owner;
              elapsed_nxt = '0;
              ptr_nxt     = q_cmd.idx;
              if (q_cmd.idx_ok) begin
                rd_en     = 1'b1;
                rd_addr   = q_cmd.idx[NOTE_AW-1:0];
                state_nxt = ST_RD;
              end else begin
                mode_nxt = MODE_STOPPED;
                en_nxt   = 1'b0;
              end
            end
            OP_TONE: begin
              mode_nxt    = MODE_PLAYING;
              single_nxt  = 1'b1;
              tpitch_nxt  = q_cmd.pitch;
              owner_nxt   = q_cmd.owner;
              elapsed_nxt = '0;
              ptr_nxt     = '0;
              ticks_nxt   = TONE_TICKS;
              prog_go     = 1'b1;
              prog_hz     = sound_pitch(q_cmd.pitch, quiet_pitch);
            end
            OP_PAUSE, OP_RESUME, OP_STOP: begin
              if (q_cmd.owner != owner_r) begin
                refused_nxt = 1'b1;
              end else if (q_cmd.op == OP_PAUSE) begin
                if (mode_r == MODE_PLAYING) begin
                  mode_nxt = MODE_PAUSED;
                  prog_go  = 1'b1;
                  prog_hz  = quiet_pitch;
                end
              end else if (q_cmd.op == OP_RESUME) begin
                if (mode_r == MODE_PAUSED) begin
                  mode_nxt = MODE_PLAYING;
                  if (single_r) begin
                    prog_go = 1'b1;
                    prog_hz = sound_pitch(tpitch_r, quiet_pitch);
                  end else if (ptr_ok) begin
                    rd_en     = 1'b1;
                    state_nxt = ST_RD;
                  end else begin
                    prog_go = 1'b1;
                    prog_hz = quiet_pitch;
                  end
                end
              end else begin
                mode_nxt    = MODE_STOPPED;
                owner_nxt   = '0;
                elapsed_nxt = '0;
                ptr_nxt     = '0;
                ticks_nxt   = '0;
                single_nxt  = 1'b0;
                en_nxt      = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_NOTE;
      end
      ST_NOTE: begin
        state_nxt = ST_OUT;
        if (cmd_r.op == OP_RESUME) begin
          prog_go = 1'b1;
          prog_hz = sound_pitch(rd_data_r[PITCH_W-1:0], quiet_pitch);
        end else if (rd_data_r[NOTE_W-1:PITCH_W] == '0) begin
          // zero duration marks the end of the song
          mode_nxt = MODE_STOPPED;
          en_nxt   = 1'b0;
        end else begin
          ticks_nxt = rd_data_r[NOTE_W-1:PITCH_W];
          prog_go   = 1'b1;
          prog_hz   = sound_pitch(rd_data_r[PITCH_W-1:0], quiet_pitch);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          div_nxt   = div_rsp.quotient;
          en_nxt    = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // program the tone counter; a zero pitch turns the speaker off
    if (prog_go) begin
      div_req.divisor = prog_hz;
      if (prog_hz == '0) begin
        en_nxt = 1'b0;
      end else begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_STOPPED;
      ptr_r     <= '0;
      ticks_r   <= '0;
      elapsed_r <= '0;
      owner_r   <= '0;
      single_r  <= 1'b0;
      tpitch_r  <= '0;
      div_r     <= '0;
      en_r      <= 1'b0;
      refused_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      ptr_r     <= ptr_nxt;
      ticks_r   <= ticks_nxt;
      elapsed_r <= elapsed_nxt;
      owner_r   <= owner_nxt;
      single_r  <= single_nxt;
      tpitch_r  <= tpitch_nxt;
      div_r     <= div_nxt;
      en_r      <= en_nxt;
      refused_r <= refused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[q_cmd.idx[NOTE_AW-1:0]] <= {q_cmd.dur, q_cmd.pitch};
    end
    if (rd_en) begin
      rd_data_r <= note_mem[rd_addr];
    end
  end

  assign out_valid                = (state_r == ST_OUT);
  assign out_data.speaker_enabled = en_r;
  assign out_data.tone_divisor    = div_r;
  assign out_data.play_state      = mode_r;
  assign out_data.current_note    = ptr_r;
  assign out_data.ticks_remaining = ticks_r;
  assign out_data.elapsed_ticks   = elapsed_r;
  assign out_data.current_owner   = owner_r;
  assign out_data.refused         = refused_r;

endmodule

FILE: src/tone_note_sequencer_unit.sv
`timescale 1ns / 1ps
// top level of the tone note sequencer: configuration registers, front, back, divider
// depends on tns_pkg, tns_front, tns_back and tns_divider

// Square-wave tone sequencer. Each input word is one command (tick, load note,
// play song, play tone, pause, resume, stop) and yields exactly one result word
// holding the state after that command. Commands enter a two-word queue, so up
// to two further words are taken while the back end works or a result waits.
// A command that reads no note and programs no pitch goes straight to its result
// in the back end. A note is read from the store in ST_RD and ST_NOTE and may end
// the song; a pitch is programmed in ST_DIV through the 24-step shared divider
// that forms tone_clock_hz / pitch. A result then waits in ST_OUT for out_ready.
// The note store is a 256 x 32 memory with one registered read port; entries
// that were never loaded read back as undefined. No clearing pass is needed.
module tone_note_sequencer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tns_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tns_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tns_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tns_pkg::*;

  logic [CLK_W-1:0]   tone_clk_r;
  logic [PITCH_W-1:0] quiet_pitch_r;
  logic               cfg_wr;
  logic               reg_sel;

  cmd_t               q_cmd;
  logic               q_valid;
  logic               q_pop;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_clk_r    <= TONE_CLK_RST;
      quiet_pitch_r <= QUIET_PITCH_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_TONE_CLK:    tone_clk_r    <= pwdata[CLK_W-1:0];
        REG_QUIET_PITCH: quiet_pitch_r <= pwdata[PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TONE_CLK:    prdata = {{(32 - CLK_W){1'b0}}, tone_clk_r};
      REG_QUIET_PITCH: prdata = {{(32 - PITCH_W){1'b0}}, quiet_pitch_r};
      default:         prdata = '0;
    endcase
  end

  tns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pop       (q_pop),
    .pop_cmd   (q_cmd),
    .not_empty (q_valid)
  );

  tns_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .tone_clk    (tone_clk_r),
    .quiet_pitch (quiet_pitch_r),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  tns_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

`ifndef NO_ASSERTIONS
  // speaker only sounds while a song or tone is active
  a_enable_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.speaker_enabled |-> out_data.play_state != MODE_STOPPED)
    else $error("speaker enabled while stopped");

  // a playing note always has ticks left
  a_playing_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.play_state == MODE_PLAYING |-> out_data.ticks_remaining != '0)
    else $error("playing with zero ticks left");

  // the divider is never restarted while busy, nor started with a zero divisor
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy && div_req.divisor != '0)
    else $error("divider started while busy or with zero divisor");

  // no word is popped from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
